>>> hdl/grid_local_maximum_finder_defines.svh
// ============================================================================
// Grid local maximum finder assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ============================================================================
`ifndef GRID_LOCAL_MAXIMUM_FINDER_DEFINES_SVH
`define GRID_LOCAL_MAXIMUM_FINDER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define GLMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid local maximum finder: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define GLMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid local maximum finder: next-cycle check failed");

`endif

>>> hdl/glmf_pkg.sv
// ============================================================================
// Grid local maximum finder package
// Shared widths, configuration register indexes and parameter defaults.
// ============================================================================
package glmf_pkg;

    // Default sizing of the line buffers and samples
    localparam int DEF_MAX_COLS    = 32;
    localparam int DEF_MAX_ROWS    = 32;
    localparam int DEF_SAMPLE_BITS = 16;

    // Result coordinate width
    localparam int PEAK_IDX_BITS = 5;
    typedef logic [PEAK_IDX_BITS-1:0] t_peak_idx;

    // Configuration port
    localparam int CFG_DATA_BITS = 6;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;
    typedef logic [0:0] t_cfg_index;

    localparam t_cfg_index CFG_GRID_ROWS = 1'd0;
    localparam t_cfg_index CFG_GRID_COLS = 1'd1;

    // Smallest legal grid dimension
    localparam t_cfg_data CFG_MIN_DIM = 6'd2;

endpackage

>>> hdl/grid_local_maximum_finder.sv
// ============================================================================
// Grid local maximum finder
// 4-neighbour local maximum detection over a row-major stream of samples.
// ============================================================================
// Usage:
//   Write grid_rows (index 0) and grid_cols (index 1) through the write port
//   while idle; each write restarts the grid. Values below 2 read as 2, values
//   above MAX_ROWS / MAX_COLS read as that maximum.
//   Samples enter on the sample channel in row-major order. A cell of row r-1
//   is decided when the sample below it is taken; its (row, col) request sits
//   in the output register in the cycle after that sample is accepted.
//   Throughput: one sample per cycle while the output register is free or
//   being drained. The row above is read two columns and the row two above one
//   column ahead of the incoming sample, so the window keeps pace at one column
//   per cycle.
//   After the last sample of a grid, the held last-row peaks drain left to
//   right, one per cycle while the receiver takes them, with o_run_last on
//   the final request; samples are held off until the drain ends.
//   If the receiver stalls, the output register holds its request and the
//   sample channel stalls with it.
//   Reset (synchronous, active low) gives a 2 x 2 grid, zeroed counters and
//   flags; line buffer contents are left as they are.
// ============================================================================
`include "grid_local_maximum_finder_defines.svh"

module grid_local_maximum_finder #(
    parameter int MAX_COLS    = glmf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = glmf_pkg::DEF_MAX_ROWS,
    parameter int SAMPLE_BITS = glmf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  glmf_pkg::t_cfg_index          i_cfg_index,
    input  glmf_pkg::t_cfg_data           i_cfg_data,
    // sample channel
    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // peak channel
    output logic                          o_peak_valid,
    input  logic                          i_peak_ready,
    output glmf_pkg::t_peak_idx           o_peak_row,
    output glmf_pkg::t_peak_idx           o_peak_col,
    output logic                          o_run_last
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // Cell wins when no existing neighbour is strictly greater
    function automatic logic is_peak(
        input t_sample cv,
        input logic hl, input t_sample lv,
        input logic hr, input t_sample rv,
        input logic hu, input t_sample uv,
        input logic hd, input t_sample dv
    );
        logic lose;
        lose = (hl && (cv < lv)) || (hr && (cv < rv)) ||
               (hu && (cv < uv)) || (hd && (cv < dv));
        return !lose;
    endfunction

    // Line buffers: row above and row two above, one entry per column
    t_sample r_mem_above [MAX_COLS];
    t_sample r_mem_two   [MAX_COLS];
    t_sample r_rd_above;
    t_sample r_rd_two;

    // Sliding window registers
    t_sample r_mid_c;
    t_sample r_mid_p;
    t_sample r_x1;
    t_sample r_x2;

    // Control state
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_last_row;
    logic [COL_W-1:0]    r_last_col;
    logic [MAX_COLS-1:0] r_flags;
    logic                r_flush;
    logic [MAX_COLS-1:0] r_flush_flags;
    logic                r_out_valid;

    // Output payload
    glmf_pkg::t_peak_idx r_out_row;
    glmf_pkg::t_peak_idx r_out_col;
    logic                r_out_last;

    logic                accept_in;
    logic                out_free;
    logic                on_last_row;
    logic                is_final;
    logic                top_pk;
    logic                bot_pk;
    logic                fin_pk;
    logic [MAX_COLS-1:0] n_flags;
    logic [COL_W-1:0]    rd_addr_above;
    logic [COL_W-1:0]    rd_addr_two;
    logic [MAX_COLS-1:0] lowest;
    logic [MAX_COLS-1:0] remaining;
    logic [COL_W-1:0]    lowest_col;
    logic [ROW_W-1:0]    cfg_last_row;
    logic [COL_W-1:0]    cfg_last_col;

    // Handshakes
    assign out_free       = !r_out_valid || i_peak_ready;
    assign o_sample_ready = !r_flush && out_free;
    assign accept_in      = i_sample_valid && o_sample_ready;

    assign o_peak_valid = r_out_valid;
    assign o_peak_row   = r_out_row;
    assign o_peak_col   = r_out_col;
    assign o_run_last   = r_out_last;

    // Clamp register writes and keep them as last indexes
    always_comb begin
        if (i_cfg_data < glmf_pkg::CFG_MIN_DIM) begin
            cfg_last_row = ROW_W'(1);
        end else if (32'(i_cfg_data) > MAX_ROWS) begin
            cfg_last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            cfg_last_row = ROW_W'(i_cfg_data - glmf_pkg::t_cfg_data'(1));
        end
        if (i_cfg_data < glmf_pkg::CFG_MIN_DIM) begin
            cfg_last_col = COL_W'(1);
        end else if (32'(i_cfg_data) > MAX_COLS) begin
            cfg_last_col = COL_W'(MAX_COLS - 1);
        end else begin
            cfg_last_col = COL_W'(i_cfg_data - glmf_pkg::t_cfg_data'(1));
        end
    end

    // Prefetch addresses: row above two columns ahead, row two above one ahead
    always_comb begin
        if (r_col == r_last_col) begin
            rd_addr_two   = '0;
            rd_addr_above = COL_W'(1);
        end else if ((r_col + COL_W'(1)) == r_last_col) begin
            rd_addr_two   = r_col + COL_W'(1);
            rd_addr_above = '0;
        end else begin
            rd_addr_two   = r_col + COL_W'(1);
            rd_addr_above = r_col + COL_W'(2);
        end
    end

    // Decide the cell above, the last-row cell to the left and the corner
    always_comb begin
        on_last_row = (r_row == r_last_row);
        is_final    = on_last_row && (r_col == r_last_col);
        top_pk = (r_row != '0) &&
                 is_peak(r_mid_c,
                         r_col != '0, r_mid_p,
                         r_col != r_last_col, r_rd_above,
                         r_row > ROW_W'(1), r_rd_two,
                         1'b1, i_sample);
        bot_pk = on_last_row && (r_col != '0) &&
                 is_peak(r_x1,
                         r_col > COL_W'(1), r_x2,
                         1'b1, i_sample,
                         1'b1, r_mid_p,
                         1'b0, i_sample);
        fin_pk = is_final &&
                 is_peak(i_sample,
                         1'b1, r_x1,
                         1'b0, i_sample,
                         1'b1, r_mid_c,
                         1'b0, i_sample);
        n_flags = r_flags;
        if (bot_pk) begin
            n_flags[r_col - COL_W'(1)] = 1'b1;
        end
        if (fin_pk) begin
            n_flags[r_col] = 1'b1;
        end
    end

    // Pick the leftmost held last-row peak
    always_comb begin
        lowest     = r_flush_flags & (~r_flush_flags + MAX_COLS'(1));
        remaining  = r_flush_flags & ~lowest;
        lowest_col = '0;
        for (int i = 0; i < MAX_COLS; i++) begin
            if (lowest[i]) begin
                lowest_col = lowest_col | COL_W'(i);
            end
        end
    end

    // Line buffers with registered reads; forward the sample on a same-column hit
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_mem_above[r_col] <= i_sample;
            if (r_row != '0) begin
                r_mem_two[r_col] <= r_mid_c;
            end
            if (rd_addr_above == r_col) begin
                r_rd_above <= i_sample;
            end else begin
                r_rd_above <= r_mem_above[rd_addr_above];
            end
            r_rd_two <= r_mem_two[rd_addr_two];
            // advance the window by one column
            r_mid_p <= r_mid_c;
            r_mid_c <= r_rd_above;
            r_x2    <= r_x1;
            r_x1    <= i_sample;
        end
    end

    // Counters, flags, drain and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row         <= '0;
            r_col         <= '0;
            r_last_row    <= ROW_W'(1);
            r_last_col    <= COL_W'(1);
            r_flags       <= '0;
            r_flush       <= 1'b0;
            r_flush_flags <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // restart the grid on a register write, else advance per sample
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    glmf_pkg::CFG_GRID_ROWS: begin
                        r_last_row <= cfg_last_row;
                    end
                    glmf_pkg::CFG_GRID_COLS: begin
                        r_last_col <= cfg_last_col;
                    end
                endcase
                r_row   <= '0;
                r_col   <= '0;
                r_flags <= '0;
            end else if (accept_in) begin
                if (is_final) begin
                    r_row   <= '0;
                    r_col   <= '0;
                    r_flags <= '0;
                end else begin
                    r_flags <= n_flags;
                    if (r_col == r_last_col) begin
                        r_col <= '0;
                        r_row <= r_row + ROW_W'(1);
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
            end

            // hand last-row peaks to the drain, then drop them one by one
            priority if (accept_in && is_final && (n_flags != '0)) begin
                r_flush       <= 1'b1;
                r_flush_flags <= n_flags;
            end else if (r_flush && out_free) begin
                r_flush_flags <= remaining;
                if (remaining == '0) begin
                    r_flush <= 1'b0;
                end
            end

            // hold a request until taken
            priority if (accept_in && top_pk) begin
                r_out_valid <= 1'b1;
            end else if (r_flush && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_peak_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        priority if (accept_in && top_pk) begin
            r_out_row  <= glmf_pkg::t_peak_idx'(r_row - ROW_W'(1));
            r_out_col  <= glmf_pkg::t_peak_idx'(r_col);
            r_out_last <= !(is_final && (n_flags != '0));
        end else if (r_flush && out_free) begin
            r_out_row  <= glmf_pkg::t_peak_idx'(r_last_row);
            r_out_col  <= glmf_pkg::t_peak_idx'(lowest_col);
            r_out_last <= (remaining == '0);
        end
    end

    // Checks
    `GLMF_ASSERT_NOW(a_col_in_grid, i_clk, i_rst_n, 1'b1, r_col <= r_last_col)
    `GLMF_ASSERT_NEXT(a_final_rearms, i_clk, i_rst_n, accept_in && is_final,
                      (r_row == '0) && (r_col == '0) && (r_flags == '0))
    `GLMF_ASSERT_NEXT(a_drain_ends_last, i_clk, i_rst_n,
                      r_flush && out_free && (remaining == '0),
                      o_peak_valid && o_run_last && !r_flush)

endmodule
